// ===== src/olt_pkg.sv =====
// Package for the ordered list table: item structs, op and status codes,
// per-cell control struct and the controller state type. No dependencies.
package olt_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_BACK  = 3'd4,
    OP_REM_AT    = 3'd5,
    OP_SEARCH    = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SRCH = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] key;
    logic [63:0]        payload;
    logic [6:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_payload;
    logic [6:0]  entry_count;
  } out_item_t;

  // Broadcast to every cell in the cycle an update is applied.
  typedef struct packed {
    logic ins;
    logic rem;
  } olt_ctrl_t;

endpackage

// ===== src/olt_cell.sv =====
// One cell of the ordered list chain: holds one entry, shifts toward either
// neighbor on insert/remove, and forwards the search token. Uses olt_pkg.
module olt_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  olt_pkg::olt_ctrl_t ctrl_i,
  input  logic [PW-1:0]      at_i,
  input  logic [PW-1:0]      cnt_i,
  input  logic [31:0]        new_key_i,
  input  logic [63:0]        new_pay_i,
  input  logic [31:0]        left_key_i,
  input  logic [63:0]        left_pay_i,
  input  logic [31:0]        right_key_i,
  input  logic [63:0]        right_pay_i,
  input  logic [31:0]        skey_i,
  input  logic               tok_i,
  input  logic               hit_i,
  input  logic [63:0]        spay_i,
  output logic [31:0]        key_o,
  output logic [63:0]        pay_o,
  output logic               tok_o,
  output logic               hit_o,
  output logic [63:0]        spay_o
);

  localparam logic [PW-1:0] MyIdx = PW'(IDX);

  logic [31:0] key_q, key_d;
  logic [63:0] pay_q, pay_d;
  logic        tok_q, hit_q;
  logic [63:0] spay_q;
  logic        match;

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if (ctrl_i.ins) begin
      if (MyIdx == at_i) begin
        key_d = new_key_i;
        pay_d = new_pay_i;
      end else if (MyIdx > at_i) begin
        key_d = left_key_i;
        pay_d = left_pay_i;
      end
    end else if (ctrl_i.rem && (MyIdx >= at_i)) begin
      key_d = right_key_i;
      pay_d = right_pay_i;
    end
  end

  assign match = tok_i && (MyIdx < cnt_i) && (key_q == skey_i);

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    pay_q  <= pay_d;
    spay_q <= match ? pay_q : spay_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
      hit_q <= hit_i | match;
    end
  end

  assign key_o  = key_q;
  assign pay_o  = pay_q;
  assign tok_o  = tok_q;
  assign hit_o  = hit_q;
  assign spay_o = spay_q;

endmodule

// ===== src/ordered_list_table_core.sv =====
// Top level of the ordered list table: controller, fill count, output
// register and the chain of olt_cell instances. Uses olt_pkg and olt_cell.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one operation
//   item: op, key, payload, position. Output channel (out_valid_o /
//   out_stall_i / out_item_o) returns exactly one result item per operation:
//   status, found_payload, entry_count. An item moves on a rising edge with
//   valid high and stall low.
//   Inserts, removals, no-ops and every operation rejected by a status check
//   are registered: the result is in the output register on the next cycle,
//   and a new item can be taken every cycle while the output is not stalled.
//   A search on a non-empty list sends a token down the cell chain, one cell
//   per cycle, collecting the last matching payload; the result is loaded
//   into the output register when the token leaves the tail cell, and only
//   then does the controller return to idle and take the next item.
//   If the receiver stalls, the result holds in the output register and the
//   input stalls until the register can take the next result.
//   Reset empties the list (fill count zero) and clears all control state;
//   entry storage is not cleared, entries beyond the fill count are never read.
module ordered_list_table_core #(
  parameter int DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  olt_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output olt_pkg::out_item_t out_item_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] CntFull = CW'(DEPTH);

  // Control state
  olt_pkg::state_e    state_q, state_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic               go_q, go_d;
  logic [31:0]        skey_q;
  logic               out_valid_q, out_valid_d;
  olt_pkg::out_item_t out_q, out_d;

  // Decode of the accepted item
  logic               acc;
  olt_pkg::olt_ctrl_t ctrl;
  logic [PW-1:0]      at;
  logic [PW-1:0]      cnt_ext, pos_ext;
  logic               res_wr;
  olt_pkg::status_e   status;

  // Chain wiring
  logic [31:0] key_w  [DEPTH];
  logic [63:0] pay_w  [DEPTH];
  logic        tok_w  [DEPTH];
  logic        hit_w  [DEPTH];
  logic [63:0] spay_w [DEPTH];
  logic        tail_tok;

  // Take an item only when idle and the output register is free this cycle.
  assign in_stall_o = (state_q != olt_pkg::S_IDLE) || (out_valid_q && out_stall_i);
  assign acc        = in_valid_i && !in_stall_o;
  assign cnt_ext    = PW'(fill_q);
  assign pos_ext    = PW'(in_item_i.position);
  assign tail_tok   = tok_w[DEPTH-1];

  always_comb begin
    ctrl    = '0;
    at      = '0;
    status  = olt_pkg::ST_OK;
    fill_d  = fill_q;
    go_d    = 1'b0;
    res_wr  = 1'b0;
    state_d = state_q;
    if (acc) begin
      res_wr = 1'b1;
      case (olt_pkg::op_e'(in_item_i.op))
        olt_pkg::OP_INS_FRONT, olt_pkg::OP_INS_BACK, olt_pkg::OP_INS_AT: begin
          if (fill_q == CntFull) begin
            status = olt_pkg::ST_FULL;
          end else if (in_item_i.op == olt_pkg::OP_INS_FRONT || fill_q == '0) begin
            at = '0;
            ctrl.ins = 1'b1;
          end else if (in_item_i.op == olt_pkg::OP_INS_BACK) begin
            at = cnt_ext;
            ctrl.ins = 1'b1;
          end else if (pos_ext > cnt_ext) begin
            status = olt_pkg::ST_BADPOS;
          end else begin
            at = pos_ext;
            ctrl.ins = 1'b1;
          end
          if (ctrl.ins) fill_d = fill_q + 1'b1;
        end
        olt_pkg::OP_REM_FRONT, olt_pkg::OP_REM_BACK, olt_pkg::OP_REM_AT: begin
          if (fill_q == '0) begin
            status = olt_pkg::ST_EMPTY;
          end else if (in_item_i.op == olt_pkg::OP_REM_FRONT) begin
            at = '0;
            ctrl.rem = 1'b1;
          end else if (in_item_i.op == olt_pkg::OP_REM_BACK) begin
            at = cnt_ext - 1'b1;
            ctrl.rem = 1'b1;
          end else if (pos_ext >= cnt_ext) begin
            status = olt_pkg::ST_BADPOS;
          end else begin
            at = pos_ext;
            ctrl.rem = 1'b1;
          end
          if (ctrl.rem) fill_d = fill_q - 1'b1;
        end
        olt_pkg::OP_SEARCH: begin
          if (fill_q == '0) begin
            status = olt_pkg::ST_EMPTY;
          end else begin
            // Defer the result until the token leaves the chain.
            go_d    = 1'b1;
            res_wr  = 1'b0;
            state_d = olt_pkg::S_SRCH;
          end
        end
        default: ;
      endcase
    end
    if (state_q == olt_pkg::S_SRCH && tail_tok) begin
      state_d = olt_pkg::S_IDLE;
    end
  end

  // Output register: hold while stalled, load a fresh result when one is ready.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (res_wr) begin
      out_valid_d         = 1'b1;
      out_d.status        = status;
      out_d.found_payload = '0;
      out_d.entry_count   = 7'(fill_d);
    end else if (state_q == olt_pkg::S_SRCH && tail_tok) begin
      out_valid_d         = 1'b1;
      out_d.status        = hit_w[DEPTH-1] ? olt_pkg::ST_OK : olt_pkg::ST_NOTFOUND;
      out_d.found_payload = hit_w[DEPTH-1] ? spay_w[DEPTH-1] : 64'd0;
      out_d.entry_count   = 7'(fill_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olt_pkg::S_IDLE;
      fill_q      <= '0;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      go_q        <= go_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (go_d) skey_q <= in_item_i.key;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Cell chain: entry i sits in cell i; data shifts one cell per update.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] lk, rk;
    logic [63:0] lp, rp;
    logic        ti, hi;
    logic [63:0] si;

    if (i == 0) begin : g_head
      assign lk = in_item_i.key;
      assign lp = in_item_i.payload;
      assign ti = go_q;
      assign hi = 1'b0;
      assign si = '0;
    end else begin : g_body
      assign lk = key_w[i-1];
      assign lp = pay_w[i-1];
      assign ti = tok_w[i-1];
      assign hi = hit_w[i-1];
      assign si = spay_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rk = key_w[i];
      assign rp = pay_w[i];
    end else begin : g_mid
      assign rk = key_w[i+1];
      assign rp = pay_w[i+1];
    end

    olt_cell #(
      .IDX (i),
      .PW  (PW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .at_i        (at),
      .cnt_i       (cnt_ext),
      .new_key_i   (in_item_i.key),
      .new_pay_i   (in_item_i.payload),
      .left_key_i  (lk),
      .left_pay_i  (lp),
      .right_key_i (rk),
      .right_pay_i (rp),
      .skey_i      (skey_q),
      .tok_i       (ti),
      .hit_i       (hi),
      .spay_i      (si),
      .key_o       (key_w[i]),
      .pay_o       (pay_w[i]),
      .tok_o       (tok_w[i]),
      .hit_o       (hit_w[i]),
      .spay_o      (spay_w[i])
    );
  end

  // Assertions
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntFull)
    else $error("fill count above DEPTH");

  a_no_update_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == olt_pkg::S_SRCH) |-> !(ctrl.ins || ctrl.rem))
    else $error("list update during search");

  a_tail_only_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_tok |-> (state_q == olt_pkg::S_SRCH))
    else $error("search token left chain outside a search");

  a_search_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_d |=> (state_q == olt_pkg::S_SRCH) && go_q)
    else $error("accepted search did not start");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> fill_q == CW'($past(fill_q) + 1'b1))
    else $error("insert did not advance fill count");

endmodule
